// ===== hdl/vni_pkg.sv =====
package vni_pkg;

	// byte width of text and font codes
	localparam int unsigned CH_W = 8;

	// output queue sizing (depth must be a power of two)
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// at most two result bytes per input byte
	localparam int unsigned RES_MAX = 2;
	localparam int unsigned RES_CNT_W = $clog2(RES_MAX + 1);

	// results of one transcode step
	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;
		logic [CH_W-1:0]      b0;
		logic [CH_W-1:0]      b1;
	} res_t;

	// one queued output byte
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} qent_t;

endpackage

// ===== hdl/vni_xlat.sv =====
module vni_xlat (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [vni_pkg::CH_W-1:0]   char_in,
	input  logic                       text_end,
	output vni_pkg::res_t              res
);

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_LETTER = 2'd1,
		KIND_MOD    = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LE = 8'h65;
	localparam logic [7:0] CH_LI = 8'h69;
	localparam logic [7:0] CH_LO = 8'h6F;
	localparam logic [7:0] CH_LU = 8'h75;
	localparam logic [7:0] CH_LY = 8'h79;
	localparam logic [7:0] CH_LD = 8'h64;
	localparam logic [7:0] CH_UD = 8'h44;
	localparam logic [7:0] CH_1  = 8'h31;
	localparam logic [7:0] CH_5  = 8'h35;
	localparam logic [7:0] CH_6  = 8'h36;
	localparam logic [7:0] CH_7  = 8'h37;
	localparam logic [7:0] CH_8  = 8'h38;
	localparam logic [7:0] CH_9  = 8'h39;

	localparam logic [7:0] MOD_A8 = 8'd128;
	localparam logic [7:0] MOD_A6 = 8'd134;
	localparam logic [7:0] MOD_E6 = 8'd140;
	localparam logic [7:0] MOD_O7 = 8'd146;
	localparam logic [7:0] MOD_O6 = 8'd152;
	localparam logic [7:0] MOD_U7 = 8'd158;
	localparam logic [7:0] CODE_LD9 = 8'd249;
	localparam logic [7:0] CODE_UD9 = 8'd250;

	// toned vowel codes, row per vowel a e i o u y, column per tone 1..5
	localparam logic [0:29][7:0] TONE_TAB = '{
		8'd164, 8'd165, 8'd166, 8'd167, 8'd168,
		8'd169, 8'd170, 8'd171, 8'd172, 8'd173,
		8'd174, 8'd175, 8'd181, 8'd182, 8'd183,
		8'd184, 8'd190, 8'd198, 8'd199, 8'd208,
		8'd210, 8'd211, 8'd212, 8'd213, 8'd214,
		8'd215, 8'd216, 8'd221, 8'd222, 8'd248
	};

	// vowel decode: {valid, index}
	function automatic logic [3:0] vowel_idx(input logic [7:0] c);
		logic [3:0] r;
		unique case (c)
			CH_LA:   r = {1'b1, 3'd0};
			CH_LE:   r = {1'b1, 3'd1};
			CH_LI:   r = {1'b1, 3'd2};
			CH_LO:   r = {1'b1, 3'd3};
			CH_LU:   r = {1'b1, 3'd4};
			CH_LY:   r = {1'b1, 3'd5};
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_tone(input logic [7:0] c);
		return (c >= CH_1) && (c <= CH_5);
	endfunction

	function automatic logic is_mod(input logic [7:0] c);
		return (c == MOD_A8) || (c == MOD_A6) || (c == MOD_E6) ||
			(c == MOD_O7) || (c == MOD_O6) || (c == MOD_U7);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		logic [3:0] v;
		v = vowel_idx(c);
		return v[3] || (c == CH_LD) || (c == CH_UD);
	endfunction

	// code of letter l followed by byte c, zero when they do not combine
	function automatic logic [7:0] combine(input logic [7:0] l, input logic [7:0] c);
		logic [3:0] v;
		logic [4:0] idx;
		logic [7:0] r;
		v   = vowel_idx(l);
		idx = 5'({2'b00, v[2:0]} * 5'd5 + {2'b00, c[2:0] - 3'd1});
		r   = 8'd0;
		if (l == CH_LD || l == CH_UD) begin
			if (c == CH_9) r = (l == CH_LD) ? CODE_LD9 : CODE_UD9;
		end else if (v[3]) begin
			if (is_tone(c)) r = TONE_TAB[idx];
			else if (l == CH_LA && c == CH_8) r = MOD_A8;
			else if (l == CH_LA && c == CH_6) r = MOD_A6;
			else if (l == CH_LE && c == CH_6) r = MOD_E6;
			else if (l == CH_LO && c == CH_7) r = MOD_O7;
			else if (l == CH_LO && c == CH_6) r = MOD_O6;
			else if (l == CH_LU && c == CH_7) r = MOD_U7;
		end
		return r;
	endfunction

	kind_t           kind_q, kind_d;
	logic [7:0]      code_q, code_d;
	logic [7:0]      comb_r;
	logic            fresh;

	// one step: resolve the pending item, then handle the byte if still fresh
	always_comb begin
		comb_r  = combine(code_q, char_in);
		fresh   = 1'b1;
		kind_d  = KIND_NONE;
		code_d  = 8'd0;
		res.cnt = '0;
		res.b0  = '0;
		res.b1  = '0;
		case (kind_q)
			KIND_LETTER: begin
				if (comb_r == 8'd0) begin
					res.b0  = code_q;
					res.cnt = 2'd1;
				end else if (is_mod(comb_r) && !text_end) begin
					kind_d = KIND_MOD;
					code_d = comb_r;
					fresh  = 1'b0;
				end else begin
					res.b0  = comb_r;
					res.cnt = 2'd1;
					fresh   = 1'b0;
				end
			end
			KIND_MOD: begin
				res.cnt = 2'd1;
				if (is_tone(char_in)) begin
					res.b0 = code_q + {5'd0, char_in[2:0]};
					fresh  = 1'b0;
				end else begin
					res.b0 = code_q;
				end
			end
			default: begin
			end
		endcase
		if (fresh) begin
			if (!text_end && is_letter(char_in)) begin
				kind_d = KIND_LETTER;
				code_d = char_in;
			end else if (!text_end && is_mod(char_in)) begin
				kind_d = KIND_MOD;
				code_d = char_in;
			end else if (res.cnt == 2'd0) begin
				res.b0  = char_in;
				res.cnt = 2'd1;
			end else begin
				res.b1  = char_in;
				res.cnt = 2'd2;
			end
		end
	end

	// pending item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			code_q <= 8'd0;
		end else if (step) begin
			kind_q <= kind_d;
			code_q <= code_d;
		end
	end

`ifndef SYNTHESIS
	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		step && text_end |=> kind_q == KIND_NONE)
		else $error("pending item left after text end");
	a_silent_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.cnt == 2'd0 |=> kind_q != KIND_NONE)
		else $error("byte consumed without result or pending item");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == KIND_NONE |-> code_q == 8'd0)
		else $error("stale pending code");
`endif

endmodule

// ===== hdl/vni_outq.sv =====
module vni_outq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vni_pkg::res_t                    push,
	output logic [vni_pkg::OQ_CNT_W-1:0]     count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [vni_pkg::CH_W-1:0]         char_out,
	output logic                             run_last
);

	localparam int unsigned DEPTH = vni_pkg::OQ_DEPTH;
	localparam int unsigned PTR_W = vni_pkg::OQ_PTR_W;
	localparam int unsigned CNT_W = vni_pkg::OQ_CNT_W;

	vni_pkg::qent_t         mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pop;
	logic [PTR_W-1:0]       wr_ptr_nx;

	assign pop       = out_valid && out_ready;
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	// queue storage
	always_ff @(posedge clk) begin
		if (push.cnt != '0) begin
			mem_q[wr_ptr_q] <= '{ch: push.b0, last: (push.cnt == vni_pkg::RES_CNT_W'(1))};
		end
		if (push.cnt == vni_pkg::RES_CNT_W'(2)) begin
			mem_q[wr_ptr_nx] <= '{ch: push.b1, last: 1'b1};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q  <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	assign count     = count_q;
	assign out_valid = (count_q != '0);
	assign char_out  = mem_q[rd_ptr_q].ch;
	assign run_last  = mem_q[rd_ptr_q].last;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("output queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != '0 |-> {1'b0, count_q} + (CNT_W + 1)'(push.cnt) <= (CNT_W + 1)'(DEPTH))
		else $error("push without room");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && push.cnt == '0 |=> count_q == $past(count_q))
		else $error("queue count moved during stall");
`endif

endmodule

// ===== hdl/vni_text_to_font_code_transcoder_top.sv =====
// an input byte passes the input register and output queue before its first
// result byte shows; a held letter or modified code waits for its resolving byte
// throughput: one input byte per cycle while it yields at most one byte,
// and out_ready holds; the single output port bounds bytes that yield two
// a 4-entry output queue decouples the output from the transcode register
// reset (arst_n low, async): nothing pending, input register and queue empty
module vni_text_to_font_code_transcoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [vni_pkg::CH_W-1:0]   char_in,
	input  logic                       text_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [vni_pkg::CH_W-1:0]   char_out,
	output logic                       run_last
);

	logic                          valid_s1;
	logic [vni_pkg::CH_W-1:0]      char_s1;
	logic                          end_s1;
	logic [vni_pkg::OQ_CNT_W-1:0]  q_count;
	logic                          room;
	logic                          step;
	vni_pkg::res_t                 res;
	vni_pkg::res_t                 push;

	// the queue must take up to two bytes from this step
	assign room     = (q_count <= vni_pkg::OQ_CNT_W'(vni_pkg::OQ_DEPTH - vni_pkg::RES_MAX));
	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			end_s1  <= text_end;
		end
	end

	vni_xlat u_xlat (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.char_in  (char_s1),
		.text_end (end_s1),
		.res      (res)
	);

	// only a taken step pushes results
	always_comb begin
		push = res;
		if (!step) push.cnt = '0;
	end

	vni_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.count     (q_count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.run_last  (run_last)
	);

endmodule

// ===== test/vni_text_to_font_code_transcoder_top_tb.sv =====
`timescale 1ns / 1ps

module vni_text_to_font_code_transcoder_top_tb;

	// modified vowel codes and d-bar codes
	localparam logic [7:0] CODE_A8 = 8'd128;
	localparam logic [7:0] CODE_A6 = 8'd134;
	localparam logic [7:0] CODE_E6 = 8'd140;
	localparam logic [7:0] CODE_O7 = 8'd146;
	localparam logic [7:0] CODE_O6 = 8'd152;
	localparam logic [7:0] CODE_U7 = 8'd158;
	localparam logic [7:0] CODE_D9_LOWER = 8'd249;
	localparam logic [7:0] CODE_D9_UPPER = 8'd250;

	localparam int RANDOM_ITEMS = 550;
	localparam int IDLE_PCT = 24;
	localparam int END_PCT = 8;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 12;

	typedef enum logic [1:0] {
		HOLD_NONE   = 2'd0,
		HOLD_LETTER = 2'd1,
		HOLD_MOD    = 2'd2
	} hold_kind_e;

	// transcoding predictor plus queue of font codes still owed by the block
	class font_code_scoreboard;
		hold_kind_e     hold_kind;
		logic [7:0]     hold_code;
		vni_pkg::qent_t expected_codes[$];
		logic [7:0]     out_buf[2];
		int             n_out;
		int             errors;
		int             checked;

		function new();
			hold_kind = HOLD_NONE;
			hold_code = 8'd0;
			errors = 0;
			checked = 0;
		endfunction

		function int vowel_slot(logic [7:0] c);
			case (c)
				"a": return 0;
				"e": return 1;
				"i": return 2;
				"o": return 3;
				"u": return 4;
				"y": return 5;
				default: return -1;
			endcase
		endfunction

		function bit is_mod_code(logic [7:0] c);
			return c == CODE_A8 || c == CODE_A6 || c == CODE_E6 ||
				c == CODE_O7 || c == CODE_O6 || c == CODE_U7;
		endfunction

		function bit is_letter(logic [7:0] c);
			return vowel_slot(c) >= 0 || c == "d" || c == "D";
		endfunction

		// toned vowel code, digit 0..4 stands for tone 1..5
		function logic [7:0] tone_code(int v, int d);
			logic [39:0] row;
			case (v)
				0: row = {8'd164, 8'd165, 8'd166, 8'd167, 8'd168};
				1: row = {8'd169, 8'd170, 8'd171, 8'd172, 8'd173};
				2: row = {8'd174, 8'd175, 8'd181, 8'd182, 8'd183};
				3: row = {8'd184, 8'd190, 8'd198, 8'd199, 8'd208};
				4: row = {8'd210, 8'd211, 8'd212, 8'd213, 8'd214};
				default: row = {8'd215, 8'd216, 8'd221, 8'd222, 8'd248};
			endcase
			return row[(4 - d) * 8 +: 8];
		endfunction

		// code made by pending letter l and byte c, zero if they do not pair
		function logic [7:0] combine(logic [7:0] l, logic [7:0] c);
			int v;
			v = vowel_slot(l);
			if (l == "d" || l == "D") begin
				if (c != "9")
					return 8'd0;
				return (l == "d") ? CODE_D9_LOWER : CODE_D9_UPPER;
			end
			if (v < 0)
				return 8'd0;
			if (c >= "1" && c <= "5")
				return tone_code(v, int'(c) - 49);
			if (l == "a" && c == "8") return CODE_A8;
			if (l == "a" && c == "6") return CODE_A6;
			if (l == "e" && c == "6") return CODE_E6;
			if (l == "o" && c == "7") return CODE_O7;
			if (l == "o" && c == "6") return CODE_O6;
			if (l == "u" && c == "7") return CODE_U7;
			return 8'd0;
		endfunction

		function void add_out(logic [7:0] b);
			out_buf[n_out] = b;
			n_out++;
		endfunction

		// work out the font codes owed for one accepted text byte
		function void note_byte(logic [7:0] c, logic e);
			logic [7:0]     made;
			logic           fresh;
			vni_pkg::qent_t r;
			int             i;
			n_out = 0;
			fresh = 1'b1;
			case (hold_kind)
				HOLD_LETTER: begin
					made = combine(hold_code, c);
					if (made == 8'd0) begin
						add_out(hold_code);
					end else if (is_mod_code(made) && !e) begin
						hold_kind = HOLD_MOD;
						hold_code = made;
						return;
					end else begin
						add_out(made);
						fresh = 1'b0;
					end
				end
				HOLD_MOD: begin
					if (c >= "1" && c <= "5") begin
						add_out(hold_code + (c - 8'd48));
						fresh = 1'b0;
					end else begin
						add_out(hold_code);
					end
				end
				default: ;
			endcase
			hold_kind = HOLD_NONE;
			hold_code = 8'd0;
			if (fresh) begin
				if (!e && is_letter(c)) begin
					hold_kind = HOLD_LETTER;
					hold_code = c;
				end else if (!e && is_mod_code(c)) begin
					hold_kind = HOLD_MOD;
					hold_code = c;
				end else begin
					add_out(c);
				end
			end
			for (i = 0; i < n_out; i++) begin
				r.ch = out_buf[i];
				r.last = (i == n_out - 1);
				expected_codes.push_back(r);
			end
		endfunction

		// compare one output transfer with the oldest owed code
		function void check_result(logic [7:0] ch, logic last);
			vni_pkg::qent_t want;
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected output transfer char_out=%0d run_last=%0b",
					$time, ch, last);
				errors++;
				return;
			end
			want = expected_codes.pop_front();
			checked++;
			if (ch !== want.ch) begin
				$display("%0t: char_out mismatch: expected %0d, actual %0d",
					$time, want.ch, ch);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: run_last mismatch: expected %0b, actual %0b",
					$time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_in;
	logic       text_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] char_out;
	logic       run_last;

	font_code_scoreboard sb;
	bit no_gaps;
	int items_sent;
	int ends_sent;
	int stall_cycles;

	vni_text_to_font_code_transcoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.text_end  (text_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.run_last  (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// output side: random back-pressure except during the steady stretch
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
	end

	// check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(char_out, run_last);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("vni_text_to_font_code_transcoder_top_tb failed");
			$finish;
		end
	end

	// offer one text byte after a random gap, return once it transfers
	task automatic send_byte(input logic [7:0] c, input logic e);
		int gap;
		gap = 0;
		if (!no_gaps)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		text_end <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(c, e);
		items_sent++;
		if (e)
			ends_sent++;
	endtask

	task automatic send_rnd(input logic [7:0] c);
		send_byte(c, $urandom_range(99) < END_PCT);
	endtask

	// one random word: mostly well-formed markup, the rest noise
	task automatic send_word();
		logic [7:0] base;
		logic [7:0] marker;
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			case ($urandom_range(7))
				0: base = "a";
				1: base = "e";
				2: base = "i";
				3: base = "o";
				4: base = "u";
				5: base = "y";
				6: base = "d";
				default: base = "D";
			endcase
			send_rnd(base);
			if (base == "d" || base == "D") begin
				if ($urandom_range(99) < 80)
					send_rnd("9");
			end else begin
				marker = 8'd0;
				case (base)
					"a": marker = $urandom_range(1) ? "8" : "6";
					"e": marker = "6";
					"o": marker = $urandom_range(1) ? "7" : "6";
					"u": marker = "7";
					default: ;
				endcase
				if (marker != 8'd0 && $urandom_range(99) < 60) begin
					send_rnd(marker);
					if ($urandom_range(99) < 70) begin
						if ($urandom_range(99) < 85)
							send_rnd(8'(49 + $urandom_range(4)));
						else
							send_rnd(8'($urandom_range(48, 57)));
					end
				end else if ($urandom_range(99) < 75) begin
					send_rnd(8'(49 + $urandom_range(4)));
				end
			end
		end else if (pick < 68) begin
			case ($urandom_range(11))
				0: marker = CODE_A8;
				1: marker = CODE_A6;
				2: marker = CODE_E6;
				3: marker = CODE_O7;
				4: marker = CODE_O6;
				5: marker = CODE_U7;
				default: marker = 8'($urandom_range(128, 255));
			endcase
			send_rnd(marker);
			if ($urandom_range(99) < 60)
				send_rnd(8'(49 + $urandom_range(4)));
		end else if (pick < 85) begin
			send_rnd(8'($urandom_range(32, 126)));
		end else begin
			send_rnd(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int random_start;
		sb = new();
		no_gaps = 1'b0;
		items_sent = 0;
		ends_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_in <= 8'd0;
		text_end <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// modifier then tone
		send_byte("a", 1'b0);
		send_byte("8", 1'b0);
		send_byte("1", 1'b0);
		// modifier with no tone after it
		send_byte("e", 1'b0);
		send_byte("6", 1'b0);
		send_byte("q", 1'b0);
		// modifier on the last byte of the text
		send_byte("u", 1'b0);
		send_byte("7", 1'b1);
		// d-bar in both cases
		send_byte("d", 1'b0);
		send_byte("9", 1'b0);
		send_byte("D", 1'b0);
		send_byte("9", 1'b0);
		// direct tone, highest table entry
		send_byte("y", 1'b0);
		send_byte("5", 1'b0);
		// uppercase vowel does not combine
		send_byte("A", 1'b0);
		send_byte("1", 1'b0);
		// zero byte and high bytes
		send_byte(8'd0, 1'b0);
		send_byte(CODE_A6, 1'b0);
		send_byte("2", 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte("o", 1'b0);
		send_byte("7", 1'b0);
		send_byte("3", 1'b1);
		// pending letter flushed by a text end that does not pair with it
		send_byte("y", 1'b0);
		send_byte("e", 1'b1);

		// random words, with one stretch free of gaps on both sides
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			no_gaps = (items_sent - random_start >= 250) &&
				(items_sent - random_start < 370);
			send_word();
		end
		no_gaps = 1'b0;
		send_byte("!", 1'b1);
		in_valid <= 1'b0;

		// drain owed codes, then give the block time to show any extra output
		while (sb.expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d text bytes in %0d texts, checked %0d output bytes",
			items_sent, ends_sent, sb.checked);
		if (sb.errors == 0 && sb.expected_codes.size() == 0)
			$display("vni_text_to_font_code_transcoder_top_tb passed");
		else
			$display("vni_text_to_font_code_transcoder_top_tb failed");
		$finish;
	end

endmodule
